// ===== hw/rtl/bmcp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmcp_pkg
// Types, character codes and helpers for the bracket motor command parser.
// ----------------------------------------------------------------------------
package bmcp_pkg;

    localparam int CHAR_W = 8;
    localparam int DIR_W  = 2;
    localparam int SPD_W  = 8;
    localparam int ACC_W  = 9;

    localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
    localparam logic [CHAR_W-1:0] CH_OPEN  = 8'h28;   // '('
    localparam logic [CHAR_W-1:0] CH_W     = 8'h57;
    localparam logic [CHAR_W-1:0] CH_S     = 8'h53;
    localparam logic [CHAR_W-1:0] CH_A     = 8'h41;
    localparam logic [CHAR_W-1:0] CH_D     = 8'h44;
    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;   // '0'
    localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;   // '9'

    localparam logic [SPD_W-1:0]  MIN_SPEED_RESET = 8'd30;
    localparam logic [SPD_W-1:0]  SPEED_MAX       = 8'd255;
    localparam logic [ACC_W-1:0]  ACC_SAT         = 9'd256;

    typedef enum logic [2:0] {
        PH_SEEK1  = 3'd0,
        PH_DIR    = 3'd1,
        PH_SEEK2  = 3'd2,
        PH_SKIP   = 3'd3,
        PH_DIGITS = 3'd4,
        PH_DONE   = 3'd5
    } phase_t;

    typedef enum logic [2:0] {
        DC_NONE = 3'd0,
        DC_W    = 3'd1,
        DC_S    = 3'd2,
        DC_A    = 3'd3,
        DC_D    = 3'd4
    } dir_code_t;

    function automatic dir_code_t dir_decode(input logic [CHAR_W-1:0] c);
        dir_code_t d;
        unique case (c)
            CH_W:    d = DC_W;
            CH_S:    d = DC_S;
            CH_A:    d = DC_A;
            CH_D:    d = DC_D;
            default: d = DC_NONE;
        endcase
        return d;
    endfunction

    function automatic logic is_digit(input logic [CHAR_W-1:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    // acc*10 + digit, saturating at 256; the low nibble of a digit is its value
    function automatic logic [ACC_W-1:0] add_digit(input logic [ACC_W-1:0] acc,
                                                   input logic [CHAR_W-1:0] c);
        logic [ACC_W+2:0] v;
        v = {acc, 3'b000} + {2'b00, acc, 1'b0} + {8'd0, c[3:0]};
        return (v > {4'd0, SPEED_MAX}) ? ACC_SAT : v[ACC_W-1:0];
    endfunction

endpackage

// ===== hw/rtl/bracket_motor_command_parser.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bracket_motor_command_parser
// Parses "(dir ... (speed" command text one byte per beat; a zero byte ends
// a message and produces one result with the held direction and speed.
// ----------------------------------------------------------------------------
// Output: a terminator beat shows its result in the cycle after acceptance.
// Throughput: one byte per cycle; the parse state and the result register
// update in the same cycle, and input stays open while a result waits as long
// as the result is taken in that cycle.
// Reset: synchronous active-low aresetn clears the parse state, the held
// command and the result register; min_speed returns to 30.
module bracket_motor_command_parser (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [bmcp_pkg::SPD_W-1:0]  cfg_data,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [bmcp_pkg::CHAR_W-1:0] s_char_byte,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic                        m_ok,
    output logic [bmcp_pkg::DIR_W-1:0]  m_direction,
    output logic [bmcp_pkg::SPD_W-1:0]  m_speed
);
    import bmcp_pkg::*;

    logic [SPD_W-1:0] min_speed_reg;
    phase_t           phase_reg, phase_next;
    dir_code_t        pdir_reg, pdir_next;
    logic [ACC_W-1:0] acc_reg, acc_next;
    logic             m_valid_reg, m_valid_next;
    logic             m_ok_reg, m_ok_next;
    logic [DIR_W-1:0] m_dir_reg, m_dir_next;
    logic [SPD_W-1:0] m_speed_reg, m_speed_next;

    logic             s_fire;
    logic             good;
    logic [ACC_W-1:0] spd_thr;
    logic [DIR_W-1:0] pdir_idx;

    assign cfg_ready = 1'b1;
    assign s_ready   = !m_valid_reg || m_ready;
    assign s_fire    = s_valid && s_ready;

    // held direction and speed live in the result payload registers
    assign good = ((phase_reg == PH_SKIP) || (phase_reg == PH_DIGITS) ||
                   (phase_reg == PH_DONE)) && (pdir_reg != DC_NONE);
    assign spd_thr  = (acc_reg < {1'b0, min_speed_reg}) ? '0 : acc_reg;
    assign pdir_idx = DIR_W'(pdir_reg - DC_W);

    always_comb begin
        phase_next   = phase_reg;
        pdir_next    = pdir_reg;
        acc_next     = acc_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_ok_next    = m_ok_reg;
        m_dir_next   = m_dir_reg;
        m_speed_next = m_speed_reg;
        if (s_fire) begin
            if (s_char_byte == CH_NUL) begin
                m_valid_next = 1'b1;
                m_ok_next    = good;
                if (good) begin
                    m_dir_next   = pdir_idx;
                    m_speed_next = spd_thr[ACC_W-1] ? SPEED_MAX : spd_thr[SPD_W-1:0];
                end
                phase_next = PH_SEEK1;
                pdir_next  = DC_NONE;
                acc_next   = '0;
            end else begin
                unique case (phase_reg)
                    PH_SEEK1: begin
                        if (s_char_byte == CH_OPEN) phase_next = PH_DIR;
                    end
                    PH_DIR: begin
                        pdir_next  = dir_decode(s_char_byte);
                        // a bracket here doubles as the second bracket
                        phase_next = (s_char_byte == CH_OPEN) ? PH_SKIP : PH_SEEK2;
                    end
                    PH_SEEK2: begin
                        if (s_char_byte == CH_OPEN) phase_next = PH_SKIP;
                    end
                    PH_SKIP: begin
                        if (is_digit(s_char_byte)) begin
                            acc_next   = add_digit(acc_reg, s_char_byte);
                            phase_next = PH_DIGITS;
                        end
                    end
                    PH_DIGITS: begin
                        if (is_digit(s_char_byte)) begin
                            acc_next = add_digit(acc_reg, s_char_byte);
                        end else begin
                            phase_next = PH_DONE;
                        end
                    end
                    default: begin
                        phase_next = PH_DONE;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_speed_reg <= MIN_SPEED_RESET;
            phase_reg     <= PH_SEEK1;
            pdir_reg      <= DC_NONE;
            acc_reg       <= '0;
            m_valid_reg   <= 1'b0;
            m_ok_reg      <= 1'b0;
            m_dir_reg     <= '0;
            m_speed_reg   <= '0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                min_speed_reg <= cfg_data;
            end
            phase_reg   <= phase_next;
            pdir_reg    <= pdir_next;
            acc_reg     <= acc_next;
            m_valid_reg <= m_valid_next;
            m_ok_reg    <= m_ok_next;
            m_dir_reg   <= m_dir_next;
            m_speed_reg <= m_speed_next;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_ok        = m_ok_reg;
    assign m_direction = m_dir_reg;
    assign m_speed     = m_speed_reg;

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the bracket motor command parser. Command text is
// streamed in one byte per beat with random gaps on both channels; a local
// parser model predicts every terminator result and the scoreboard compares
// ok, direction and speed against it, across several min_speed settings.
// ----------------------------------------------------------------------------
module testbench;

    import bmcp_pkg::*;

    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_PHASES  = 4;
    localparam int PHASE_BYTES    = 160;

    typedef logic [CHAR_W-1:0] msg_t[$];

    typedef struct {
        logic             ok;
        logic [DIR_W-1:0] dir;
        logic [SPD_W-1:0] spd;
    } command_t;

    logic              aclk        = 1'b0;
    logic              aresetn     = 1'b0;
    logic              cfg_valid   = 1'b0;
    logic              cfg_ready;
    logic [SPD_W-1:0]  cfg_data    = '0;
    logic              s_valid     = 1'b0;
    logic              s_ready;
    logic [CHAR_W-1:0] s_char_byte = '0;
    logic              m_valid;
    logic              m_ready     = 1'b0;
    logic              m_ok;
    logic [DIR_W-1:0]  m_direction;
    logic [SPD_W-1:0]  m_speed;

    // parser model state
    phase_t            parse_ph = PH_SEEK1;
    dir_code_t         pend_dir = DC_NONE;
    logic [ACC_W-1:0]  acc      = '0;
    logic [DIR_W-1:0]  held_dir = '0;
    logic [SPD_W-1:0]  held_spd = '0;
    logic [SPD_W-1:0]  min_spd  = MIN_SPEED_RESET;

    command_t          pending_cmds[$];
    logic [CHAR_W-1:0] steer_chars[4] = '{CH_W, CH_S, CH_A, CH_D};
    string             steer_names[4] = '{"W", "S", "A", "D"};

    bit idle_on  = 1'b1;
    bit hold_req = 1'b0;
    int err_count, bytes_in, cmds_checked, good_cmds, min_writes, holds_done;
    int quiet_cycles;

    bracket_motor_command_parser uut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_char_byte (s_char_byte),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_ok        (m_ok),
        .m_direction (m_direction),
        .m_speed     (m_speed)
    );

    initial begin
        forever #10 aclk = ~aclk;
    end

    function automatic bit numeral(input logic [CHAR_W-1:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    function automatic logic [ACC_W-1:0] push_digit(input logic [ACC_W-1:0] a,
                                                    input logic [CHAR_W-1:0] c);
        int v;
        v = int'(a) * 10 + int'(c - CH_ZERO);
        return (v > 255) ? ACC_SAT : ACC_W'(v);
    endfunction

    // advance the parser model by one byte; a terminator queues one result
    function automatic void parse_char(input logic [CHAR_W-1:0] c);
        command_t r;
        int       v;
        if (c == CH_NUL) begin
            r.ok = 1'b0;
            if (parse_ph inside {PH_SKIP, PH_DIGITS, PH_DONE} && pend_dir != DC_NONE) begin
                v = int'(acc);
                if (v < int'(min_spd)) v = 0;
                if (v > 255) v = 255;
                held_dir = DIR_W'(int'(pend_dir) - int'(DC_W));
                held_spd = SPD_W'(v);
                r.ok     = 1'b1;
            end
            r.dir = held_dir;
            r.spd = held_spd;
            pending_cmds.push_back(r);
            parse_ph = PH_SEEK1;
            pend_dir = DC_NONE;
            acc      = '0;
        end else begin
            case (parse_ph)
                PH_SEEK1: begin
                    if (c == CH_OPEN) parse_ph = PH_DIR;
                end
                PH_DIR: begin
                    case (c)
                        CH_W:    pend_dir = DC_W;
                        CH_S:    pend_dir = DC_S;
                        CH_A:    pend_dir = DC_A;
                        CH_D:    pend_dir = DC_D;
                        default: pend_dir = DC_NONE;
                    endcase
                    // a bracket in the direction slot doubles as the second one
                    parse_ph = (c == CH_OPEN) ? PH_SKIP : PH_SEEK2;
                end
                PH_SEEK2: begin
                    if (c == CH_OPEN) parse_ph = PH_SKIP;
                end
                PH_SKIP: begin
                    if (numeral(c)) begin
                        acc      = push_digit(acc, c);
                        parse_ph = PH_DIGITS;
                    end
                end
                PH_DIGITS: begin
                    if (numeral(c)) acc = push_digit(acc, c);
                    else parse_ph = PH_DONE;
                end
                default: parse_ph = PH_DONE;
            endcase
        end
    endfunction

    function automatic void report(input string msg);
        err_count++;
        if (err_count <= 10) $display("%s", msg);
    endfunction

    // all handshakes are sampled at the edge, before any update of that edge lands
    always @(posedge aclk) begin
        command_t want;
        if (aresetn) begin
            if (cfg_valid && cfg_ready) begin
                min_spd = cfg_data;
                min_writes++;
            end
            if (s_valid && s_ready) begin
                bytes_in++;
                parse_char(s_char_byte);
            end
            if (m_valid && m_ready) begin
                if (pending_cmds.size() == 0) begin
                    report($sformatf("unexpected result beat: ok=%0d dir=%0d speed=%0d",
                                     m_ok, m_direction, m_speed));
                end else begin
                    want = pending_cmds.pop_front();
                    cmds_checked++;
                    if (want.ok) good_cmds++;
                    if (m_ok !== want.ok || m_direction !== want.dir || m_speed !== want.spd)
                        report($sformatf({"result mismatch: expected ok=%0d dir=%0d speed=%0d,",
                                          " got ok=%0d dir=%0d speed=%0d"},
                                         want.ok, want.dir, want.spd,
                                         m_ok, m_direction, m_speed));
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) ||
            (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("timeout: no beat accepted for %0d cycles", WATCHDOG_LIMIT);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // result side: random stalls, plus one long hold-off on request
    initial begin
        forever begin
            @(posedge aclk);
            if (hold_req) begin
                hold_req = 1'b0;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                holds_done++;
            end
            m_ready <= !(idle_on && $urandom_range(0, 99) < 8);
        end
    end

    task automatic send_byte(input logic [CHAR_W-1:0] c);
        if (idle_on && $urandom_range(0, 99) < 8) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_char_byte <= c;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic send_msg(input msg_t m);
        foreach (m[i]) send_byte(m[i]);
        send_byte(CH_NUL);
    endtask

    function automatic msg_t text(input string s);
        msg_t q;
        for (int i = 0; i < s.len(); i++) q.push_back(s[i]);
        return q;
    endfunction

    // stop offering and wait until every predicted result has been taken
    task automatic drain();
        s_valid <= 1'b0;
        while (pending_cmds.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_min_speed(input logic [SPD_W-1:0] v);
        drain();
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [CHAR_W-1:0] filler();
        logic [CHAR_W-1:0] c;
        do c = CHAR_W'($urandom_range(1, 255)); while (c == CH_OPEN || numeral(c));
        return c;
    endfunction

    task automatic test_directed();
        send_byte(CH_NUL);                 // empty message
        send_msg(text("(W(120"));
        send_msg(text("(S(30"));           // exactly at the threshold
        send_msg(text("(A(29"));           // just under it
        send_msg(text("(D(256"));
        send_msg(text("(W(99999999999"));  // way past int range
        send_msg(text("(X(50"));           // bad direction
        send_msg(text("((77"));            // bracket in the direction slot
        send_msg(text("(W"));              // ends before the second bracket
        send_msg(text("(D("));             // bracket but no digits
        send_msg(text("(A(:/x90y12"));     // skip non-digits, ignore the tail
        send_msg(text("zz(S junk (45 7"));
        send_byte(CH_OPEN);
        send_byte(8'hFF);
        send_byte(CH_OPEN);
        send_byte(8'h80);
        send_byte(CH_NINE);
        send_byte(CH_NUL);
        drain();
    endtask

    task automatic test_min_speed();
        int levels[5];
        int k;
        levels = '{0, 255, 1, 128, $urandom_range(2, 254)};
        foreach (levels[i]) begin
            write_min_speed(SPD_W'(levels[i]));
            k = $urandom_range(0, 3);
            if (levels[i] > 0)
                send_msg(text($sformatf("(%s(%0d", steer_names[k], levels[i] - 1)));
            send_msg(text($sformatf("(%s(%0d", steer_names[(k + 1) % 4], levels[i])));
            send_msg(text($sformatf("(%s(%0d", steer_names[(k + 2) % 4], levels[i] + 1)));
            send_msg(text($sformatf("(%s(0", steer_names[(k + 3) % 4])));
            send_msg(text("(D(300"));
        end
        drain();
    endtask

    task automatic test_random();
        msg_t m;
        int   sent;
        int   n;
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            write_min_speed(($urandom_range(0, 3) == 0) ? SPD_W'($urandom_range(0, 255))
                                                        : SPD_W'($urandom_range(0, 60)));
            idle_on = (p != 2);   // one phase runs without any idle cycles
            sent = 0;
            while (sent < PHASE_BYTES) begin
                if ($urandom_range(0, 99) < 15) begin
                    n = $urandom_range(1, 8);
                    repeat (n) send_byte(CHAR_W'($urandom_range(0, 255)));
                    sent += n;
                end else begin
                    m = {};
                    repeat ($urandom_range(0, 2)) m.push_back(filler());
                    m.push_back(CH_OPEN);
                    if ($urandom_range(0, 99) < 80) m.push_back(steer_chars[$urandom_range(0, 3)]);
                    else m.push_back(CHAR_W'($urandom_range(1, 255)));
                    repeat ($urandom_range(0, 2)) m.push_back(filler());
                    if ($urandom_range(0, 9) != 0) m.push_back(CH_OPEN);
                    repeat ($urandom_range(0, 2)) m.push_back(filler());
                    n = ($urandom_range(0, 9) == 0) ? $urandom_range(4, 12) : $urandom_range(0, 3);
                    repeat (n) m.push_back(CH_ZERO + CHAR_W'($urandom_range(0, 9)));
                    repeat ($urandom_range(0, 3)) m.push_back(CHAR_W'($urandom_range(1, 255)));
                    send_msg(m);
                    sent += m.size() + 1;
                end
            end
            send_byte(CH_NUL);    // close any open message before the next setting
        end
        idle_on = 1'b1;
        drain();
    endtask

    task automatic test_backpressure();
        hold_req = 1'b1;
        repeat (30) begin
            if ($urandom_range(0, 1) == 0) send_byte(CH_NUL);
            else send_msg(text($sformatf("(%s(%0d", steer_names[$urandom_range(0, 3)],
                                         $urandom_range(0, 255))));
        end
        drain();
    endtask

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed();
        test_min_speed();
        test_random();
        test_backpressure();
        write_min_speed(MIN_SPEED_RESET);

        err_count += pending_cmds.size();
        $display("run covered %0d bytes, %0d results checked (%0d good commands)",
                 bytes_in, cmds_checked, good_cmds);
        $display("min_speed written %0d times, %0d long output hold-offs, %0d errors",
                 min_writes, holds_done, err_count);
        if (err_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

// ===== files.f =====
hw/rtl/bmcp_pkg.sv
hw/rtl/bracket_motor_command_parser.sv
tb/testbench.sv
